// File: rtl/wlcf_pkg.sv
// Shared types and constants for the word list censor filter.
`default_nettype none
package wlcf_pkg;
  localparam int NumWords = 16;
  localparam int MaxLen = 16;
  localparam int WIdxW = $clog2(NumWords);
  localparam int PosW = $clog2(MaxLen);
  localparam int LenW = $clog2(MaxLen + 1);
  localparam int CntW = 5;
  localparam logic [7:0] StarChar = 8'h2a;
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_TEXT  = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // Command handed from the front to the back.
  typedef struct packed {
    req_t             kind;
    logic [WIdxW-1:0] word_index;
    logic [PosW-1:0]  char_pos;
    logic [7:0]       char_value;
    logic             word_end;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_EMPTY
  } state_t;
endpackage
`default_nettype wire

// File: rtl/wlcf_front.sv
// Front: accepts input beats, classifies them, queues commands.
`default_nettype none
module wlcf_front import wlcf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [3:0]  word_index,
  input  wire logic [3:0]  char_pos,
  input  wire logic [7:0]  char_value,
  input  wire logic        word_end,
  output logic             cmd_valid,
  input  wire logic        cmd_ready,
  output cmd_t             cmd
);
  cmd_t q [QDepth];
  logic [$clog2(QDepth+1)-1:0] count;
  logic rd_ptr, wr_ptr;
  logic push, pop;
  cmd_t incoming;

  always_comb begin
    incoming.kind = req_t'(req_type);
    incoming.word_index = word_index[WIdxW-1:0];
    incoming.char_pos = char_pos[PosW-1:0];
    incoming.char_value = char_value;
    incoming.word_end = word_end;
  end

  assign in_ready = (count != 2'(QDepth));
  // Unknown request codes are dropped here and never reach the back.
  assign push = in_valid && in_ready && (incoming.kind != REQ_NONE);
  assign cmd_valid = (count != '0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= incoming;
    if (rst) begin
      count <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// File: rtl/wlcf_back.sv
// Back: word table, lookahead window, match scan and output register.
`default_nettype none
module wlcf_back import wlcf_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [CntW-1:0] word_count,
  input  wire logic            cmd_valid,
  output logic                 cmd_ready,
  input  cmd_t                 cmd,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_char,
  output logic                 out_has,
  output logic                 out_last
);
  // One row per word, bytes packed from the lowest bits up.
  logic [MaxLen*8-1:0] pat [NumWords];
  logic [LenW-1:0] plen [NumWords];
  logic [7:0]      win [MaxLen];
  logic [LenW-1:0] fill;

  state_t state, state_next;
  logic [WIdxW:0]  widx;        // word under test
  logic            flushing;
  logic [LenW-1:0] emit_len, emit_i;

  logic [WIdxW:0]  n_words;
  logic            cur_match;
  logic [LenW-1:0] cur_len;
  logic            slot_free;
  logic            take_out;

  assign n_words = (word_count > CntW'(NumWords)) ? (WIdxW+1)'(NumWords)
                                                 : (WIdxW+1)'(word_count);
  assign cur_len = plen[widx[WIdxW-1:0]];

  always_comb begin
    cur_match = (cur_len != '0) && (cur_len <= fill);
    for (int i = 0; i < MaxLen; i++) begin
      if (LenW'(i) < cur_len && pat[widx[WIdxW-1:0]][i*8 +: 8] != win[i]) cur_match = 1'b0;
    end
  end

  assign slot_free = !out_valid || out_ready;
  assign cmd_ready = (state == ST_IDLE) && slot_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && slot_free) begin
          if (cmd.kind == REQ_TEXT && fill == LenW'(MaxLen - 1)) state_next = ST_SCAN;
          else if (cmd.kind == REQ_FLUSH)
            state_next = (fill == '0) ? ST_EMPTY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (widx >= n_words || cur_match) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free && emit_i == emit_len - 1'b1) begin
          // flushing with more bytes left after this beat: resolve the next head
          if (flushing && fill != LenW'(1)) state_next = ST_SCAN;
          else state_next = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign take_out = slot_free && (state == ST_EMIT || state == ST_EMPTY);

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid && slot_free && cmd.kind == REQ_LOAD)
      pat[cmd.word_index][{cmd.char_pos, 3'b000} +: 8] <= cmd.char_value;
    if (state == ST_IDLE && cmd_valid && slot_free && cmd.kind == REQ_TEXT)
      win[fill[PosW-1:0]] <= cmd.char_value;
    if (state == ST_SCAN) begin
      widx <= widx + 1'b1;
      emit_i <= '0;
      emit_len <= (widx < n_words && cur_match) ? cur_len : LenW'(1);
    end
    if (state == ST_IDLE) widx <= '0;
    if (state == ST_EMIT && slot_free) begin
      out_char <= (emit_i == '0 || emit_i == emit_len - 1'b1) ? win[0] : StarChar;
      out_has <= 1'b1;
      out_last <= flushing && fill == LenW'(1);
      for (int i = 0; i < MaxLen - 1; i++) win[i] <= win[i+1];
      emit_i <= emit_i + 1'b1;
      widx <= '0;
    end
    if (state == ST_EMPTY && slot_free) begin
      out_char <= 8'h00;
      out_has <= 1'b0;
      out_last <= 1'b1;
    end
    if (rst) begin
      state <= ST_IDLE;
      fill <= '0;
      out_valid <= 1'b0;
      flushing <= 1'b0;
      for (int w = 0; w < NumWords; w++) plen[w] <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (take_out) out_valid <= 1'b1;
      if (state == ST_EMIT && slot_free) fill <= fill - 1'b1;
      if (state == ST_IDLE && cmd_valid && slot_free) begin
        flushing <= (cmd.kind == REQ_FLUSH);
        if (cmd.kind == REQ_TEXT) fill <= fill + 1'b1;
        if (cmd.kind == REQ_LOAD && cmd.word_end)
          plen[cmd.word_index] <= LenW'(cmd.char_pos) + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/word_list_censor_filter_unit.sv
// Top level of the word list censor filter.
//
//  channel | dir | handshake                | payload
//  s_axis  | in  | s_axis_tvalid/tready     | tdata: req_type, word_index, char_pos,
//          |     |                          |        char_value, word_end
//  m_axis  | out | m_axis_tvalid/tready     | tdata: out_char; tuser: has_char, tlast: is_last
//  cfg     | in  | cfg_we                   | cfg_wdata: word_count
//
// A text beat that fills the window scans the word table one word per cycle
// until a word matches or the table ends, then emits one beat per character of
// the matched word, or a single beat for the head character when none matches.
// A flush repeats scan and emit until the window is empty; a flush of an empty
// window emits a single beat with has_char low and is_last set.
// A two-entry queue parts input acceptance from the scan engine; the output
// register holds a beat while m_axis_tready is low. rst is synchronous and
// clears the window fill, word lengths and control state.
`default_nettype none
module word_list_censor_filter_unit import wlcf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [1:0] req_type, [5:2] word_index, [9:6] char_pos, [17:10] char_value,
  // [18] word_end, [23:19] zero
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_char
  output logic             m_axis_tuser,   // [0] has_char
  output logic             m_axis_tlast    // is_last
);
  logic [CntW-1:0] word_count;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) word_count <= '0;
    else if (cfg_we) word_count <= cfg_wdata;
  end

  wlcf_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .req_type(s_axis_tdata[1:0]), .word_index(s_axis_tdata[5:2]),
    .char_pos(s_axis_tdata[9:6]), .char_value(s_axis_tdata[17:10]),
    .word_end(s_axis_tdata[18]),
    .cmd_valid, .cmd_ready, .cmd
  );

  wlcf_back u_back (
    .clk, .rst, .word_count,
    .cmd_valid, .cmd_ready, .cmd,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_char(m_axis_tdata), .out_has(m_axis_tuser), .out_last(m_axis_tlast)
  );
endmodule
`default_nettype wire
